// ----- src/adm_pkg.sv -----
package adm_pkg;

  // Width of the packed diagonal vector and the longest pattern it serves.
  localparam int unsigned STATE_BITS  = 64;
  localparam int unsigned MAX_PATTERN = 32;

  // Field widths fixed by the interface.
  localparam int unsigned SYM_W   = 3;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned ERR_W   = 5;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned CODE_W  = 2;
  localparam int unsigned PAT_W   = CODE_W * MAX_PATTERN;
  localparam int unsigned IDX_W   = 2;

  // Shift amounts into the vector, with one spare bit for the running offset.
  localparam int unsigned SH_W    = $clog2(STATE_BITS) + 1;
  localparam int unsigned VIDX_W  = $clog2(STATE_BITS);

  // One mask per DNA base plus one for any other character.
  localparam int unsigned NUM_MASKS = 5;
  localparam logic [SYM_W-1:0] SYM_A     = 3'd0;
  localparam logic [SYM_W-1:0] SYM_C     = 3'd1;
  localparam logic [SYM_W-1:0] SYM_T     = 3'd2;
  localparam logic [SYM_W-1:0] SYM_G     = 3'd3;
  localparam logic [SYM_W-1:0] SYM_OTHER = 3'd4;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] CFG_IDX_PATTERN = 2'd0;
  localparam logic [IDX_W-1:0] CFG_IDX_LENGTH  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_IDX_ERRORS  = 2'd2;

  // Everything the step logic needs from the configuration.
  typedef struct packed {
    logic [NUM_MASKS-1:0][STATE_BITS-1:0] sym;
    logic [STATE_BITS-1:0]                init_vec;
    logic [STATE_BITS-1:0]                sep;
    logic [MAX_PATTERN-1:0]               field;
    logic [ERR_W-1:0]                     k;
    logic                                 bad;
  } adm_masks_t;

endpackage

// ----- src/adm_cfg.sv -----
module adm_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [adm_pkg::IDX_W-1:0]         cfg_index_i,
  input  logic [adm_pkg::PAT_W-1:0]         cfg_data_i,
  output adm_pkg::adm_masks_t               masks_o,
  output logic                              busy_o
);

  typedef enum logic [3:0] {
    ST_RUN   = 4'b0001,
    ST_LOAD  = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_DONE  = 4'b1000
  } adm_state_e;

  adm_state_e                     state_q, state_d;
  adm_pkg::adm_masks_t            masks_q, masks_d;
  logic [adm_pkg::PAT_W-1:0]      pat_q;
  logic [adm_pkg::LEN_W-1:0]      len_q;
  logic [adm_pkg::ERR_W-1:0]      err_q;

  logic [adm_pkg::NUM_MASKS-1:0][adm_pkg::MAX_PATTERN-1:0] mism_q, mism_d, mism_new;
  logic [adm_pkg::ERR_W-1:0]      d_q, d_d;
  logic [adm_pkg::LEN_W-1:0]      ndiag_q, ndiag_d;
  logic [adm_pkg::SH_W-1:0]       sh_q, sh_d;

  logic [adm_pkg::LEN_W-1:0]      diag_cnt;
  logic [adm_pkg::LEN_W-1:0]      k_plus2;
  logic [12:0]                    span;
  logic                           bad_new;
  logic [adm_pkg::MAX_PATTERN-1:0] field_new;
  logic                           cfg_hit;

  // Validity of the requested geometry and the per-diagonal field mask.
  assign diag_cnt  = len_q - {1'b0, err_q};
  assign k_plus2   = {1'b0, err_q} + adm_pkg::LEN_W'(2);
  assign span      = 13'(diag_cnt) * 13'(k_plus2);
  assign bad_new   = ({1'b0, err_q} >= len_q) ||
                     (len_q > adm_pkg::LEN_W'(adm_pkg::MAX_PATTERN)) ||
                     (span > 13'(adm_pkg::STATE_BITS));
  assign field_new = ~({adm_pkg::MAX_PATTERN{1'b1}} << ({1'b0, err_q} + adm_pkg::LEN_W'(1)));

  // Mismatch vectors: bit j is set when pattern position j is in use and
  // does not hold the base of that mask. The last mask mismatches everywhere.
  always_comb begin
    for (int c = 0; c < adm_pkg::NUM_MASKS; c++) begin
      for (int j = 0; j < adm_pkg::MAX_PATTERN; j++) begin
        mism_new[c][j] = (adm_pkg::LEN_W'(j) < len_q) &&
                         ((c == adm_pkg::NUM_MASKS - 1) ||
                          (pat_q[adm_pkg::CODE_W*j +: adm_pkg::CODE_W] !=
                           adm_pkg::CODE_W'(c)));
      end
    end
  end

  assign cfg_hit = cfg_we_i && ((cfg_index_i == adm_pkg::CFG_IDX_PATTERN) ||
                                (cfg_index_i == adm_pkg::CFG_IDX_LENGTH) ||
                                (cfg_index_i == adm_pkg::CFG_IDX_ERRORS));

  // Mask builder: one diagonal per cycle, each placed at its running offset.
  always_comb begin
    state_d = state_q;
    masks_d = masks_q;
    mism_d  = mism_q;
    d_d     = d_q;
    sh_d    = sh_q;
    ndiag_d = ndiag_q;
    unique case (state_q)
      ST_RUN: begin
        state_d = ST_RUN;
      end
      ST_LOAD: begin
        masks_d.sym      = '0;
        masks_d.init_vec = '0;
        masks_d.sep      = '0;
        masks_d.field    = bad_new ? '0 : field_new;
        masks_d.k        = err_q;
        masks_d.bad      = bad_new;
        mism_d           = mism_new;
        d_d              = '0;
        sh_d             = '0;
        ndiag_d          = diag_cnt;
        state_d          = bad_new ? ST_DONE : ST_SWEEP;
      end
      ST_SWEEP: begin
        for (int c = 0; c < adm_pkg::NUM_MASKS; c++) begin
          masks_d.sym[c] = masks_q.sym[c] |
              (adm_pkg::STATE_BITS'(mism_q[c] & masks_q.field) << sh_q);
          mism_d[c]      = mism_q[c] >> 1;
        end
        masks_d.init_vec = masks_q.init_vec |
                           (adm_pkg::STATE_BITS'(masks_q.field) << sh_q);
        masks_d.sep      = masks_q.sep | (adm_pkg::STATE_BITS'(1) << sh_q);
        d_d              = d_q + adm_pkg::ERR_W'(1);
        sh_d             = sh_q + adm_pkg::SH_W'(masks_q.k) + adm_pkg::SH_W'(2);
        if ({1'b0, d_q} == ndiag_q - adm_pkg::LEN_W'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_RUN;
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
    if (cfg_hit) begin
      state_d = ST_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      pat_q   <= '0;
      len_q   <= adm_pkg::LEN_W'(1);
      err_q   <= '0;
      // Masks for the reset configuration: one A, no errors.
      masks_q.sym      <= {{(adm_pkg::NUM_MASKS-1){adm_pkg::STATE_BITS'(1)}},
                           adm_pkg::STATE_BITS'(0)};
      masks_q.init_vec <= adm_pkg::STATE_BITS'(1);
      masks_q.sep      <= adm_pkg::STATE_BITS'(1);
      masks_q.field    <= adm_pkg::MAX_PATTERN'(1);
      masks_q.k        <= '0;
      masks_q.bad      <= 1'b0;
      d_q     <= '0;
      sh_q    <= '0;
      ndiag_q <= '0;
    end else begin
      state_q <= state_d;
      masks_q <= masks_d;
      d_q     <= d_d;
      sh_q    <= sh_d;
      ndiag_q <= ndiag_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          adm_pkg::CFG_IDX_PATTERN: begin
            pat_q <= cfg_data_i;
          end
          adm_pkg::CFG_IDX_LENGTH: begin
            len_q <= cfg_data_i[adm_pkg::LEN_W-1:0];
          end
          adm_pkg::CFG_IDX_ERRORS: begin
            err_q <= cfg_data_i[adm_pkg::ERR_W-1:0];
          end
          default: begin
            pat_q <= pat_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mism_q <= mism_d;
  end

  assign masks_o = masks_q;
  assign busy_o  = (state_q != ST_RUN);

endmodule

// ----- src/adm_core.sv -----
module adm_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  adm_pkg::adm_masks_t         masks_i,
  input  logic                        busy_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [adm_pkg::SYM_W-1:0]   symbol_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        match_found_o,
  output logic [adm_pkg::POS_W-1:0]   end_position_o,
  output logic                        config_error_o
);

  logic                              s1_valid_q;
  logic [adm_pkg::SYM_W-1:0]         s1_sym_q;
  logic                              out_valid_q;
  logic                              match_q;
  logic [adm_pkg::POS_W-1:0]         pos_out_q;
  logic                              err_out_q;
  logic [adm_pkg::STATE_BITS-1:0]    dv_q, dv_d;
  logic [adm_pkg::POS_W-1:0]         pos_q;

  logic                              out_free;
  logic                              s1_adv;
  logic                              accept;

  logic [adm_pkg::SYM_W-1:0]         midx;
  logic [adm_pkg::STATE_BITS-1:0]    sm, x, subst, ins, diag, nv, field_w;
  logic [adm_pkg::LEN_W-1:0]         k2, k3;
  logic [adm_pkg::VIDX_W-1:0]        kidx;
  logic                              found;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = busy_i || (s1_valid_q && !out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // One step of the diagonal automaton.
  assign midx    = (s1_sym_q <= adm_pkg::SYM_G) ? s1_sym_q : adm_pkg::SYM_OTHER;
  assign sm      = masks_i.sym[midx];
  assign k2      = {1'b0, masks_i.k} + adm_pkg::LEN_W'(2);
  assign k3      = {1'b0, masks_i.k} + adm_pkg::LEN_W'(3);
  assign kidx    = adm_pkg::VIDX_W'(masks_i.k);
  assign field_w = adm_pkg::STATE_BITS'(masks_i.field);

  assign x     = (dv_q >> k2) | sm;
  assign subst = (dv_q << 1) | masks_i.sep;
  assign ins   = (dv_q << k3) | (masks_i.sep << k2) | field_w;
  assign diag  = ((x + masks_i.sep) ^ x) >> 1;
  assign nv    = subst & ins & diag & masks_i.init_vec;
  assign found = !masks_i.bad && !nv[kidx];

  always_comb begin
    dv_d = dv_q;
    if (!masks_i.bad) begin
      dv_d = nv | (adm_pkg::STATE_BITS'(1) << kidx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      dv_q        <= adm_pkg::STATE_BITS'(1);
      pos_q       <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (busy_i) begin
        dv_q  <= masks_i.init_vec;
        pos_q <= '0;
      end else if (s1_adv) begin
        dv_q  <= dv_d;
        pos_q <= pos_q + adm_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sym_q <= symbol_i;
    end
    if (s1_adv) begin
      match_q   <= found;
      pos_out_q <= pos_q;
      err_out_q <= masks_i.bad;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign match_found_o  = match_q;
  assign end_position_o = pos_out_q;
  assign config_error_o = err_out_q;

endmodule

// ----- src/approx_dna_match_by_diagonals.sv -----
// Each accepted symbol is first held in an input register. Its automaton step
// is registered into the output register once that is free, and is presented
// from there. One symbol per cycle is taken unless busy or output stalls.
// A register write rebuilds the masks one diagonal per cycle: inputs are
// stalled in the load, sweep and done states; a bad setting skips the sweep.
// Reset (rst_ni low, asynchronous) loads the masks of the default
// configuration directly, so symbols are taken right after reset.
module approx_dna_match_by_diagonals (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [adm_pkg::IDX_W-1:0]   cfg_index_i,
  input  logic [adm_pkg::PAT_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [adm_pkg::SYM_W-1:0]   symbol_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        match_found_o,
  output logic [adm_pkg::POS_W-1:0]   end_position_o,
  output logic                        config_error_o
);

  // The configuration block holds the pattern, length and error limit, and
  // derives the packed symbol masks, initial vector, separator mask and field
  // mask. On a write to one of its registers it clears the masks and, if
  // the setting is usable, ORs in one diagonal of k+1 state bits per cycle
  // at offset d*(k+2). While it works it asserts busy, which stalls input,
  // keeps the diagonal vector at the initial vector and the position at zero.
  adm_pkg::adm_masks_t masks;
  logic                busy;

  adm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .masks_o     (masks),
    .busy_o      (busy)
  );

  // The core registers each accepted item, then advances the automaton once
  // the output is free: shift the vector for the three transitions, add the
  // separator mask to propagate along the diagonals, and AND the results.
  // A clear bit k signals a match, after which bit k is set again. The
  // output register lets the next item enter while a result waits.
  adm_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .masks_i        (masks),
    .busy_i         (busy),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .symbol_i       (symbol_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .match_found_o  (match_found_o),
    .end_position_o (end_position_o),
    .config_error_o (config_error_o)
  );

endmodule

// ----- tb/tb_approx_dna_match_by_diagonals.sv -----
`timescale 1ns / 100ps

module tb_approx_dna_match_by_diagonals;

  // The driver streams text symbols from a queue, and the monitor samples both
  // handshakes at the rising edge. A behavioral copy of the automaton runs
  // alongside. Every symbol the block accepts is stepped through that copy,
  // and the result it gives is queued. Result items from the block are then
  // compared field by field against that queue, oldest first.

  // The fourth register index does not exist, and a write to it must be ignored.
  localparam logic [adm_pkg::IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
  localparam logic [adm_pkg::SYM_W-1:0] SYM_TOP        = {adm_pkg::SYM_W{1'b1}};

  typedef struct packed {
    logic                      found;
    logic [adm_pkg::POS_W-1:0] pos;
    logic                      bad;
  } match_report_t;

  logic                         clk_i;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic [adm_pkg::IDX_W-1:0]    cfg_index_i = adm_pkg::CFG_IDX_PATTERN;
  logic [adm_pkg::PAT_W-1:0]    cfg_data_i  = '0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  logic [adm_pkg::SYM_W-1:0]    symbol_i    = adm_pkg::SYM_A;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic                         match_found_o;
  logic [adm_pkg::POS_W-1:0]    end_position_o;
  logic                         config_error_o;

  approx_dna_match_by_diagonals dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .symbol_i       (symbol_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .match_found_o  (match_found_o),
    .end_position_o (end_position_o),
    .config_error_o (config_error_o)
  );

  // Registers as the block should hold them, and what they imply for the automaton.
  logic [adm_pkg::PAT_W-1:0]      pat_q;
  logic [adm_pkg::LEN_W-1:0]      len_q;
  logic [adm_pkg::ERR_W-1:0]      err_q;
  logic [adm_pkg::STATE_BITS-1:0] sym_mask [adm_pkg::NUM_MASKS];
  logic [adm_pkg::STATE_BITS-1:0] init_mask;
  logic [adm_pkg::STATE_BITS-1:0] sep_bits;
  logic [adm_pkg::STATE_BITS-1:0] field_bits;
  int unsigned                    k_cur;
  logic                           cfg_bad;
  logic [adm_pkg::STATE_BITS-1:0] diag_vec;
  logic [adm_pkg::POS_W-1:0]      pos_cnt;

  logic [adm_pkg::SYM_W-1:0] text_q [$];
  match_report_t             report_q [$];

  int  send_idle_pct = 0;
  int  stall_pct     = 0;
  int  hold_left     = 0;
  int  symbols_queued = 0;
  int  symbols_taken  = 0;
  int  matches_seen   = 0;
  int  writes_seen    = 0;
  int  err_count      = 0;
  logic sym_taken     = 1'b0;

  task automatic log_error(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    err_count++;
  endtask

  // Rebuild the packed symbol masks for the current pattern, then restart the search.
  // Each of the (m-k) diagonals gets k+1 state bits; the lowest is its separator.
  function automatic void rebuild_masks();
    logic [adm_pkg::STATE_BITS-1:0] miss [adm_pkg::NUM_MASKS];
    int unsigned m, k, d, c, j, sh;
    m = len_q;
    k = err_q;
    for (c = 0; c < adm_pkg::NUM_MASKS; c++) sym_mask[c] = '0;
    init_mask  = '0;
    sep_bits   = '0;
    field_bits = '0;
    k_cur      = k;
    cfg_bad    = (k >= m) || (m > adm_pkg::MAX_PATTERN) ||
                 ((m - k) * (k + 2) > adm_pkg::STATE_BITS);
    if (!cfg_bad) begin
      field_bits = (64'd1 << (k + 1)) - 64'd1;
      for (c = 0; c < adm_pkg::NUM_MASKS; c++) miss[c] = (64'd1 << m) - 64'd1;
      // A cleared bit means that pattern position j accepts this base.
      // The mask for any other character keeps all its bits set.
      for (j = 0; j < m; j++) miss[pat_q[2*j +: 2]][j] = 1'b0;
      for (d = 0; d < m - k; d++) begin
        sh = d * (k + 2);
        for (c = 0; c < adm_pkg::NUM_MASKS; c++)
          sym_mask[c] |= ((miss[c] >> d) & field_bits) << sh;
        init_mask |= field_bits << sh;
        sep_bits  |= 64'd1 << sh;
      end
    end
    diag_vec = init_mask;
    pos_cnt  = '0;
  endfunction

  function automatic void apply_register(input logic [adm_pkg::IDX_W-1:0] idx,
                                         input logic [adm_pkg::PAT_W-1:0] value);
    case (idx)
      adm_pkg::CFG_IDX_PATTERN: pat_q = value;
      adm_pkg::CFG_IDX_LENGTH:  len_q = value[adm_pkg::LEN_W-1:0];
      adm_pkg::CFG_IDX_ERRORS:  err_q = value[adm_pkg::ERR_W-1:0];
      default: return;
    endcase
    rebuild_masks();
  endfunction

  // One step of the automaton. The diagonal shift is done with a single add:
  // the carry runs from each separator bit up through its own field.
  function automatic match_report_t automaton_step(input logic [adm_pkg::SYM_W-1:0] s);
    match_report_t r;
    logic [adm_pkg::STATE_BITS-1:0] x, subst, ins, dg, dv;
    int unsigned idx, k;
    idx     = (s <= adm_pkg::SYM_G) ? s : adm_pkg::SYM_OTHER;
    r.found = 1'b0;
    r.pos   = pos_cnt;
    r.bad   = cfg_bad;
    pos_cnt = pos_cnt + 1'b1;
    if (!cfg_bad) begin
      k     = k_cur;
      dv    = diag_vec;
      x     = (dv >> (k + 2)) | sym_mask[idx];
      subst = (dv << 1) | sep_bits;
      ins   = (dv << (k + 3)) | (sep_bits << (k + 2)) | field_bits;
      dg    = ((x + sep_bits) ^ x) >> 1;
      dv    = subst & ins & dg & init_mask;
      // The last cell of the first diagonal is active. Report the match, then
      // set the bit again to rearm that diagonal.
      if (!dv[k]) begin
        r.found = 1'b1;
        dv[k]   = 1'b1;
      end
      diag_vec = dv;
    end
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Monitor. It checks result items first, then tracks symbol handshakes and
  // register writes, so the order inside one clock edge is fixed.
  always @(posedge clk_i) begin
    match_report_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (report_q.size() == 0) begin
          log_error($sformatf("result item with nothing outstanding, position %0d",
                              end_position_o));
        end else begin
          want = report_q.pop_front();
          if (match_found_o !== want.found)
            log_error($sformatf("position %0d: match_found %b, want %b",
                                want.pos, match_found_o, want.found));
          if (end_position_o !== want.pos)
            log_error($sformatf("end_position %0d, want %0d", end_position_o, want.pos));
          if (config_error_o !== want.bad)
            log_error($sformatf("position %0d: config_error %b, want %b",
                                want.pos, config_error_o, want.bad));
        end
        if (match_found_o === 1'b1) matches_seen++;
      end
      sym_taken = in_valid_i && !in_stall_o;
      if (sym_taken) begin
        report_q.push_back(automaton_step(symbol_i));
        symbols_taken++;
      end
      if (cfg_we_i) begin
        apply_register(cfg_index_i, cfg_data_i);
        writes_seen++;
      end
    end
  end

  // Driver. A new symbol is offered only once the previous one has been
  // taken. A stalled symbol stays on the port unchanged.
  always @(negedge clk_i) begin
    if (!in_valid_i || sym_taken) begin
      if (text_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        symbol_i   <= text_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // The receiver stalls at random. It also holds off for a long stretch when
  // asked. That stretch is counted down here, one cycle at a time.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic push_symbol(input logic [adm_pkg::SYM_W-1:0] s);
    text_q.push_back(s);
    symbols_queued++;
  endtask

  function automatic logic [adm_pkg::SYM_W-1:0] rand_symbol();
    if ($urandom_range(0, 9) != 0)
      return adm_pkg::SYM_W'($urandom_range(adm_pkg::SYM_A, adm_pkg::SYM_G));
    return adm_pkg::SYM_W'($urandom_range(adm_pkg::SYM_OTHER, SYM_TOP));
  endfunction

  // Queues about n symbols. With even odds each step queues a copy of the
  // pattern with occasional deletions, insertions and substitutions, so that
  // matches both near the error limit and beyond it come up often, or one
  // random background symbol, with some foreign characters mixed in.
  task automatic queue_text(input int n);
    int target, m, j, r;
    target = symbols_queued + n;
    m      = (len_q > adm_pkg::MAX_PATTERN) ? adm_pkg::MAX_PATTERN : len_q;
    while (symbols_queued < target) begin
      if (m > 0 && $urandom_range(0, 1) == 1) begin
        for (j = 0; j < m; j++) begin
          r = $urandom_range(0, 19);
          if (r == 0) continue;
          if (r == 1) push_symbol(rand_symbol());
          push_symbol((r == 2) ? rand_symbol() : {1'b0, pat_q[2*j +: 2]});
        end
      end else begin
        push_symbol(rand_symbol());
      end
    end
  endtask

  // The block is idle once every queued symbol has produced its result.
  task automatic wait_drained();
    while (symbols_queued != symbols_taken || report_q.size() != 0) @(negedge clk_i);
  endtask

  // Before each write, allow for the pipeline latency and let any mask
  // rebuild still running finish first.
  task automatic write_register(input logic [adm_pkg::IDX_W-1:0] idx,
                                input logic [adm_pkg::PAT_W-1:0] value);
    repeat (4) @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Writes all three registers in a rotating order. The unused upper bits of
  // the length and error writes carry random data that the block must drop.
  task automatic set_search(input logic [adm_pkg::PAT_W-1:0] pattern, input int m,
                            input int k);
    logic [adm_pkg::PAT_W-1:0] len_word, err_word;
    int first, i;
    wait_drained();
    len_word = {$urandom, $urandom};
    err_word = {$urandom, $urandom};
    len_word[adm_pkg::LEN_W-1:0] = adm_pkg::LEN_W'(m);
    err_word[adm_pkg::ERR_W-1:0] = adm_pkg::ERR_W'(k);
    first = $urandom_range(0, 2);
    for (i = 0; i < 3; i++) begin
      case ((first + i) % 3)
        0: write_register(adm_pkg::CFG_IDX_PATTERN, pattern);
        1: write_register(adm_pkg::CFG_IDX_LENGTH, len_word);
        default: write_register(adm_pkg::CFG_IDX_ERRORS, err_word);
      endcase
    end
  endtask

  task automatic run_phase(input logic [adm_pkg::PAT_W-1:0] pattern, input int m,
                           input int k, input int n, input int idle, input int stall);
    set_search(pattern, m, k);
    send_idle_pct = idle;
    stall_pct     = stall;
    queue_text(n);
  endtask

  // Picks a usable k and m: the (m-k) packed diagonals must fit the state
  // vector, and m is at most MAX_PATTERN. Mostly small k, sometimes any k.
  task automatic pick_valid(output int m, output int k);
    int dmax;
    k    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 6);
    dmax = adm_pkg::STATE_BITS / (k + 2);
    if (dmax > adm_pkg::MAX_PATTERN - k) dmax = adm_pkg::MAX_PATTERN - k;
    m    = k + $urandom_range(1, dmax);
  endtask

  initial begin
    int m, k, ph, s;
    int idle_mix [4];
    int stall_mix [4];
    logic [adm_pkg::PAT_W-1:0] acgt;
    idle_mix  = '{0, 77, 0, 13};
    stall_mix = '{0, 0, 77, 13};

    // After reset the block holds the default search: pattern "A", m = 1, k = 0.
    pat_q = '0;
    len_q = adm_pkg::LEN_W'(1);
    err_q = '0;
    rebuild_masks();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Every base and every foreign code goes through the
    // default one-symbol search.
    for (s = adm_pkg::SYM_A; s <= SYM_TOP; s++) push_symbol(adm_pkg::SYM_W'(s));

    // "ACGT" with one error allowed. The text has an exact hit, a hit with one
    // deletion, and a foreign character that breaks an occurrence.
    acgt = adm_pkg::PAT_W'({adm_pkg::CODE_W'(adm_pkg::SYM_T), adm_pkg::CODE_W'(adm_pkg::SYM_G),
                            adm_pkg::CODE_W'(adm_pkg::SYM_C), adm_pkg::CODE_W'(adm_pkg::SYM_A)});
    set_search(acgt, 4, 1);
    push_symbol(adm_pkg::SYM_A); push_symbol(adm_pkg::SYM_C);
    push_symbol(adm_pkg::SYM_G); push_symbol(adm_pkg::SYM_T);
    push_symbol(adm_pkg::SYM_A); push_symbol(adm_pkg::SYM_C);
    push_symbol(adm_pkg::SYM_T); push_symbol(adm_pkg::SYM_G);
    push_symbol(adm_pkg::SYM_A); push_symbol(adm_pkg::SYM_OTHER);
    push_symbol(adm_pkg::SYM_C);
    push_symbol(adm_pkg::SYM_G); push_symbol(adm_pkg::SYM_T);

    // A write to the unused index must neither restart the search nor reset
    // the position count.
    wait_drained();
    write_register(CFG_IDX_UNUSED, {$urandom, $urandom});
    push_symbol(adm_pkg::SYM_A); push_symbol(adm_pkg::SYM_C);

    // Unusable searches, one for each reason: k equal to m, m of zero,
    // m above the maximum, and diagonals too wide for the state vector.
    set_search({$urandom, $urandom}, 3, 3);
    push_symbol(adm_pkg::SYM_G);
    set_search({$urandom, $urandom}, 0, 0);
    push_symbol(adm_pkg::SYM_A);
    set_search({$urandom, $urandom}, 33, 2);
    push_symbol(adm_pkg::SYM_C);
    set_search({$urandom, $urandom}, 20, 5);
    push_symbol(adm_pkg::SYM_T);

    // Random part. It starts at the extremes: the longest pattern with no
    // errors allowed, then the largest error limit.
    run_phase({adm_pkg::PAT_W{1'b1}}, adm_pkg::MAX_PATTERN, 0, 60, 0, 0);
    run_phase({$urandom, $urandom}, adm_pkg::MAX_PATTERN, adm_pkg::MAX_PATTERN - 1,
              50, 77, 0);
    pick_valid(m, k);
    run_phase({$urandom, $urandom}, m, k, 60, 0, 77);

    // Midway through this phase the sender stops until every result is back.
    pick_valid(m, k);
    run_phase({$urandom, $urandom}, m, k, 30, 13, 13);
    wait_drained();
    queue_text(30);

    // Backpressure: the receiver holds off for a long stretch while the
    // sender keeps offering. The pipeline fills, and the block stalls its input.
    set_search({$urandom, $urandom}, 10, 2);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 40;
    queue_text(30);

    for (ph = 0; ph < 4; ph++) begin
      pick_valid(m, k);
      run_phase({$urandom, $urandom}, m, k, 50, idle_mix[ph], stall_mix[ph]);
    end

    k = $urandom_range(0, 31);
    m = $urandom_range(0, k);
    run_phase({$urandom, $urandom}, m, k, 20, 13, 13);
    run_phase('0, 1, 0, 30, 0, 0);

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (report_q.size() != 0)
      log_error($sformatf("%0d result items never arrived", report_q.size()));

    $display("Covered: %0d symbols checked over %0d register writes, %0d matches reported.",
             symbols_taken, writes_seen, matches_seen);
    $display("Searches included usable and unusable settings, stalls and long backpressure.");
    if (err_count == 0) begin
      $display("tb_approx_dna_match_by_diagonals: PASS");
    end else begin
      $display("tb_approx_dna_match_by_diagonals: FAIL");
    end
    $finish;
  end

  // Watchdog. It is set far beyond the slowest correct run, even with every
  // stall and every mask rebuild counted.
  initial begin
    #5_000_000;
    $display("Timed out with %0d result items outstanding.", report_q.size());
    $display("tb_approx_dna_match_by_diagonals: FAIL");
    $finish;
  end

endmodule
